[rtl/spms_pkg.sv]
package spms_pkg;

  localparam int unsigned SLOTS_DEF  = 256;
  localparam int unsigned STACKS_DEF = 3;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOP  = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_RESP
  } state_e;

  // per-port RAM strobes
  typedef struct packed {
    logic re;
    logic we;
  } ram_ctl_t;

endpackage

[rtl/spms_if.sv]
interface spms_in_if;
  logic                              valid;
  logic                              ready;
  logic [spms_pkg::MODE_W-1:0]       mode;
  logic [spms_pkg::SEL_W-1:0]        stack_sel;
  logic signed [spms_pkg::DATA_W-1:0] data_in;

  modport source (output valid, mode, stack_sel, data_in, input ready);
  modport sink   (input valid, mode, stack_sel, data_in, output ready);
endinterface

interface spms_out_if;
  logic                               valid;
  logic                               ready;
  logic [spms_pkg::STATUS_W-1:0]      status;
  logic signed [spms_pkg::DATA_W-1:0] data_out;

  modport source (output valid, status, data_out, input ready);
  modport sink   (input valid, status, data_out, output ready);
endinterface

[rtl/spms_ram.sv]
module spms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  spms_pkg::ram_ctl_t       ctl_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end else if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/spms_ctrl.sv]
module spms_ctrl #(
  parameter int unsigned SLOTS  = spms_pkg::SLOTS_DEF,
  parameter int unsigned STACKS = spms_pkg::STACKS_DEF,
  localparam int unsigned AW    = $clog2(SLOTS),
  localparam int unsigned PW    = $clog2(SLOTS + 1),
  localparam int unsigned SDW   = spms_pkg::DATA_W + PW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  spms_in_if.sink            in_i,
  spms_out_if.source         out_o,
  // used-mark RAM
  output spms_pkg::ram_ctl_t used_ctl_o,
  output logic [AW-1:0]      used_addr_o,
  output logic               used_wdata_o,
  input  logic               used_rdata_i,
  // data + link RAM
  output spms_pkg::ram_ctl_t slot_ctl_o,
  output logic [AW-1:0]      slot_addr_o,
  output logic [SDW-1:0]     slot_wdata_o,
  input  logic [SDW-1:0]     slot_rdata_i
);

  localparam int unsigned SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);
  localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

  spms_pkg::state_e state_q, state_d;

  logic [PW-1:0] top_q [STACKS];
  logic [PW-1:0] scan_q;
  logic [PW-1:0] clr_q;
  logic          out_valid_q;

  logic [spms_pkg::MODE_W-1:0]       mode_q;
  logic [SW-1:0]                     sel_q;
  logic signed [spms_pkg::DATA_W-1:0] din_q;
  logic [PW-1:0]                     cur_q;
  logic [PW-1:0]                     ptr_q;
  logic [spms_pkg::STATUS_W-1:0]     res_status_q;
  logic [spms_pkg::DATA_W-1:0]       res_data_q;
  logic [spms_pkg::STATUS_W-1:0]     out_status_q;
  logic [spms_pkg::DATA_W-1:0]       out_data_q;

  logic          accept;
  logic          sel_ok;
  logic [SW-1:0] sel_idx;
  logic [PW-1:0] top_in;
  logic          top_empty;
  logic          scan_full;
  logic          push_go;
  logic          look_go;
  logic [PW-1:0] ptr_next;
  logic          out_free;
  logic [PW-1:0] link;
  logic [spms_pkg::STATUS_W-1:0] acc_status;

  assign sel_ok    = 32'(in_i.stack_sel) < 32'(STACKS);
  assign sel_idx   = SW'(in_i.stack_sel);
  assign top_in    = sel_ok ? top_q[sel_idx] : NIL;
  assign top_empty = (top_in == NIL);
  assign scan_full = (scan_q == NIL);
  assign accept    = in_i.valid && in_i.ready;
  assign push_go   = (in_i.mode == spms_pkg::MODE_PUSH) && sel_ok && !scan_full;
  assign look_go   = ((in_i.mode == spms_pkg::MODE_POP) || (in_i.mode == spms_pkg::MODE_TOP))
                     && !top_empty;
  assign ptr_next  = ptr_q + PW'(1);
  assign out_free  = !out_valid_q || out_o.ready;
  assign link      = slot_rdata_i[PW-1:0];

  assign in_i.ready     = (state_q == spms_pkg::S_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.data_out = out_data_q;

  always_comb begin
    unique case (in_i.mode)
      spms_pkg::MODE_PUSH: acc_status = push_go ? spms_pkg::STAT_DONE : spms_pkg::STAT_FULL;
      spms_pkg::MODE_POP,
      spms_pkg::MODE_TOP:  acc_status = top_empty ? spms_pkg::STAT_EMPTY : spms_pkg::STAT_DONE;
      default:             acc_status = spms_pkg::STAT_DONE;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spms_pkg::S_CLEAR: begin
        if (clr_q == LAST) state_d = spms_pkg::S_IDLE;
      end
      spms_pkg::S_IDLE: begin
        if (accept) begin
          if (push_go) state_d = spms_pkg::S_SCAN;
          else if (look_go) state_d = spms_pkg::S_LOOK;
          else state_d = spms_pkg::S_RESP;
        end
      end
      spms_pkg::S_LOOK: state_d = spms_pkg::S_RESP;
      spms_pkg::S_SCAN: begin
        if (!used_rdata_i || ptr_next == NIL) state_d = spms_pkg::S_RESP;
      end
      spms_pkg::S_RESP: begin
        if (out_free) state_d = spms_pkg::S_IDLE;
      end
      default: state_d = spms_pkg::S_IDLE;
    endcase
  end

  // RAM strobes
  always_comb begin
    used_ctl_o   = '0;
    used_addr_o  = ptr_q[AW-1:0];
    used_wdata_o = 1'b0;
    slot_ctl_o   = '0;
    slot_addr_o  = ptr_q[AW-1:0];
    slot_wdata_o = {din_q, top_q[sel_q]};
    unique case (state_q)
      spms_pkg::S_CLEAR: begin
        used_ctl_o.we = 1'b1;
        used_addr_o   = clr_q[AW-1:0];
      end
      spms_pkg::S_IDLE: begin
        if (accept && push_go) begin
          used_ctl_o.re = 1'b1;
          used_addr_o   = scan_q[AW-1:0];
        end
        if (accept && look_go) begin
          slot_ctl_o.re = 1'b1;
          slot_addr_o   = top_in[AW-1:0];
        end
      end
      spms_pkg::S_LOOK: begin
        if (mode_q == spms_pkg::MODE_POP) begin
          used_ctl_o.we = 1'b1;
          used_addr_o   = cur_q[AW-1:0];
        end
      end
      spms_pkg::S_SCAN: begin
        if (!used_rdata_i) begin
          // free slot found: claim it and store data + link
          used_ctl_o.we = 1'b1;
          used_wdata_o  = 1'b1;
          slot_ctl_o.we = 1'b1;
        end else if (ptr_next != NIL) begin
          used_ctl_o.re = 1'b1;
          used_addr_o   = ptr_next[AW-1:0];
        end
      end
      spms_pkg::S_RESP: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spms_pkg::S_CLEAR;
      scan_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(STACKS); i++) top_q[i] <= NIL;
    end else begin
      state_q <= state_d;
      if (state_q == spms_pkg::S_CLEAR) clr_q <= clr_q + PW'(1);
      if (state_q == spms_pkg::S_LOOK && mode_q == spms_pkg::MODE_POP) begin
        top_q[sel_q] <= (link < NIL) ? link : NIL;
        if (cur_q < scan_q) scan_q <= cur_q;
      end
      if (state_q == spms_pkg::S_SCAN) begin
        if (!used_rdata_i) begin
          top_q[sel_q] <= ptr_q;
          scan_q       <= ptr_q;
        end else if (ptr_next == NIL) begin
          scan_q <= NIL;
        end
      end
      if (state_q == spms_pkg::S_RESP && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // transaction payload
  always_ff @(posedge clk_i) begin
    if (state_q == spms_pkg::S_IDLE && accept) begin
      mode_q       <= in_i.mode;
      sel_q        <= sel_idx;
      din_q        <= in_i.data_in;
      cur_q        <= top_in;
      ptr_q        <= scan_q;
      res_status_q <= acc_status;
      res_data_q   <= '0;
    end
    if (state_q == spms_pkg::S_LOOK && mode_q == spms_pkg::MODE_TOP) begin
      res_data_q <= slot_rdata_i[SDW-1:PW];
    end
    if (state_q == spms_pkg::S_SCAN && used_rdata_i) begin
      ptr_q <= ptr_next;
      if (ptr_next == NIL) res_status_q <= spms_pkg::STAT_FULL;
    end
    if (state_q == spms_pkg::S_RESP && out_free) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
    end
  end

endmodule

[rtl/shared_pool_multi_stack.sv]
// Shared-pool multi-stack: STACKS stacks share one pool of SLOTS slots.
// Request channel in_i (valid/ready): mode (push, pop, read top), stack_sel,
// data_in. Response channel out_o (valid/ready): status (done, stack empty,
// pool full) and data_out (top value on a read top, zero otherwise).
// Exactly one response transaction per request transaction, in order.
// Pop and read top pass through a RAM read state and a response state before
// out_o.valid rises; rejected requests and mode 3 skip the RAM read. in_i.ready
// rises with the response load, so a new request is taken only once the last
// one's response has loaded.
// A push walks the used-mark RAM one slot per cycle from the lowest
// possibly-free slot, stepping over occupied slots; right after pops it
// usually finds the first slot it reads free.
// Reset: all stacks empty. After reset a clearing pass writes SLOTS entries of
// the used-mark RAM, one per cycle; in_i.ready stays low during the pass.
// Stall: a response waits in the output register while out_o.ready is low; the
// next request is still accepted and worked up to its response, which then
// holds until the output register frees.
module shared_pool_multi_stack #(
  parameter int unsigned SLOTS  = spms_pkg::SLOTS_DEF,
  parameter int unsigned STACKS = spms_pkg::STACKS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  spms_in_if.sink    in_i,
  spms_out_if.source out_o
);

  localparam int unsigned AW  = $clog2(SLOTS);
  localparam int unsigned PW  = $clog2(SLOTS + 1);
  localparam int unsigned SDW = spms_pkg::DATA_W + PW;

  // used marks, one bit per slot
  spms_pkg::ram_ctl_t used_ctl;
  logic [AW-1:0]      used_addr;
  logic               used_wdata;
  logic               used_rdata;

  // slot word: {data, link to slot below}
  spms_pkg::ram_ctl_t slot_ctl;
  logic [AW-1:0]      slot_addr;
  logic [SDW-1:0]     slot_wdata;
  logic [SDW-1:0]     slot_rdata;

  spms_ctrl #(
    .SLOTS  (SLOTS),
    .STACKS (STACKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .out_o        (out_o),
    .used_ctl_o   (used_ctl),
    .used_addr_o  (used_addr),
    .used_wdata_o (used_wdata),
    .used_rdata_i (used_rdata),
    .slot_ctl_o   (slot_ctl),
    .slot_addr_o  (slot_addr),
    .slot_wdata_o (slot_wdata),
    .slot_rdata_i (slot_rdata)
  );

  spms_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .ctl_i   (used_ctl),
    .addr_i  (used_addr),
    .wdata_i (used_wdata),
    .rdata_o (used_rdata)
  );

  // no clearing: entries are read only after a push wrote them
  spms_ram #(
    .WIDTH (SDW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .ctl_i   (slot_ctl),
    .addr_i  (slot_addr),
    .wdata_i (slot_wdata),
    .rdata_o (slot_rdata)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SLOTS  = spms_pkg::SLOTS_DEF;
  localparam int unsigned STACKS = spms_pkg::STACKS_DEF;

  localparam int unsigned DATA_W   = spms_pkg::DATA_W;
  localparam int unsigned MODE_W   = spms_pkg::MODE_W;
  localparam int unsigned SEL_W    = spms_pkg::SEL_W;
  localparam int unsigned STATUS_W = spms_pkg::STATUS_W;

  // mode 3 is not an operation; the block answers done and does nothing
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  // stack select 3 names a stack that does not exist
  localparam logic [SEL_W-1:0]  SEL_NONE = 2'd3;

  localparam int unsigned RANDOM_OPS = 1425;
  localparam int unsigned DRAIN_WAIT = SLOTS + 40;  // worst push scan plus margin
  localparam int unsigned MAX_SHOWN  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
  } stack_resp_t;

  // directed row: operation, plus a hand-written answer when `known` is set
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SEL_W-1:0]    sel;
    logic [DATA_W-1:0]   data;
    logic                known;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   value;
  } op_row_t;

  localparam int unsigned NUM_ROWS = 25;

  // Walks empty reads, the missing stack, ignored mode, data extremes, a pop
  // that frees slot 0 so the next push refills it, then drains everything.
  localparam op_row_t DIRECTED_OPS [NUM_ROWS] = '{
    '{spms_pkg::MODE_TOP,  2'd0,     32'h0000_0000, 1'b1, spms_pkg::STAT_EMPTY, 32'h0000_0000},
    '{spms_pkg::MODE_POP,  2'd0,     32'hFFFF_FFFF, 1'b1, spms_pkg::STAT_EMPTY, 32'h0000_0000},
    '{spms_pkg::MODE_POP,  2'd2,     32'h0000_0000, 1'b1, spms_pkg::STAT_EMPTY, 32'h0000_0000},
    '{spms_pkg::MODE_PUSH, SEL_NONE, 32'h1234_5678, 1'b1, spms_pkg::STAT_FULL,  32'h0000_0000},
    '{spms_pkg::MODE_POP,  SEL_NONE, 32'h0000_0000, 1'b1, spms_pkg::STAT_EMPTY, 32'h0000_0000},
    '{spms_pkg::MODE_TOP,  SEL_NONE, 32'h0000_0000, 1'b1, spms_pkg::STAT_EMPTY, 32'h0000_0000},
    '{MODE_NOP,            2'd0,     32'hDEAD_BEEF, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_PUSH, 2'd0,     32'h7FFF_FFFF, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd0,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'h7FFF_FFFF},
    '{spms_pkg::MODE_PUSH, 2'd1,     32'h8000_0000, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_PUSH, 2'd2,     32'hFFFF_FFFF, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_PUSH, 2'd2,     32'h0000_0000, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd2,     32'hFFFF_FFFF, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd1,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'h8000_0000},
    '{spms_pkg::MODE_POP,  2'd0,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_PUSH, 2'd1,     32'hA5A5_A5A5, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd1,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'hA5A5_A5A5},
    '{spms_pkg::MODE_POP,  2'd1,     32'h0000_0000, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd1,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'h8000_0000},
    '{spms_pkg::MODE_PUSH, SEL_NONE, 32'hFFFF_FFFF, 1'b1, spms_pkg::STAT_FULL,  32'h0000_0000},
    '{MODE_NOP,            SEL_NONE, 32'h5A5A_5A5A, 1'b1, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_POP,  2'd2,     32'h0000_0000, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_TOP,  2'd2,     32'h0000_0000, 1'b1, spms_pkg::STAT_DONE,  32'hFFFF_FFFF},
    '{spms_pkg::MODE_POP,  2'd1,     32'h0000_0000, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000},
    '{spms_pkg::MODE_POP,  2'd2,     32'h0000_0000, 1'b0, spms_pkg::STAT_DONE,  32'h0000_0000}
  };

  logic clk_i;
  logic rst_ni;

  spms_in_if  req_if ();
  spms_out_if rsp_if ();

  shared_pool_multi_stack #(
    .SLOTS  (SLOTS),
    .STACKS (STACKS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // 50 MHz
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the pool. Link of a slot is the top it replaced, so it is
  // either a written slot or SLOTS (empty); a pop can copy it back directly.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] pool_data [SLOTS];
  logic              pool_used [SLOTS];
  logic [8:0]        pool_link [SLOTS];
  logic [8:0]        top_ptr   [STACKS];
  logic [8:0]        free_hint;   // lowest slot that may be free

  stack_resp_t resp_q [$];        // answers owed by the block, oldest first

  int unsigned err_cnt;
  int unsigned n_push, n_pop, n_top, n_ignored, n_full, n_empty;

  function automatic stack_resp_t apply_stack_op(logic [MODE_W-1:0] m,
                                                 logic [SEL_W-1:0] s,
                                                 logic [DATA_W-1:0] d);
    stack_resp_t r;
    int unsigned p;
    r.status = spms_pkg::STAT_DONE;
    r.value  = '0;
    case (m)
      spms_pkg::MODE_PUSH: begin
        if (s >= STACKS) begin
          r.status = spms_pkg::STAT_FULL;
        end else begin
          p = free_hint;
          while (p < SLOTS && pool_used[p]) p++;
          free_hint = 9'(p);
          if (p >= SLOTS) begin
            r.status = spms_pkg::STAT_FULL;
          end else begin
            pool_used[p] = 1'b1;
            pool_data[p] = d;
            pool_link[p] = top_ptr[s];
            top_ptr[s]   = 9'(p);
          end
        end
      end
      spms_pkg::MODE_POP: begin
        if (s >= STACKS || top_ptr[s] >= SLOTS) begin
          r.status = spms_pkg::STAT_EMPTY;
        end else begin
          p = top_ptr[s];
          top_ptr[s]   = pool_link[p];
          pool_used[p] = 1'b0;
          if (p < free_hint) free_hint = 9'(p);
        end
      end
      spms_pkg::MODE_TOP: begin
        if (s >= STACKS || top_ptr[s] >= SLOTS) r.status = spms_pkg::STAT_EMPTY;
        else r.value = pool_data[top_ptr[s]];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_SHOWN) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. valid is raised with the payload and held until a rising
  // edge sees ready; the next call either keeps it high with new payload or
  // drops it for a gap, so valid gets a single update per edge.
  // ---------------------------------------------------------------------------
  task automatic issue(input logic [MODE_W-1:0] m, input logic [SEL_W-1:0] s,
                       input logic [DATA_W-1:0] d, input int unsigned gap,
                       input logic known, input stack_resp_t want);
    stack_resp_t got;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.stack_sel <= s;
    req_if.data_in   <= d;
    do @(posedge clk_i); while (!req_if.ready);
    // transaction taken at this edge
    got = apply_stack_op(m, s, d);
    resp_q.push_back(known ? want : got);
    if (m == MODE_NOP || s == SEL_NONE) n_ignored++;
    else if (m == spms_pkg::MODE_PUSH) n_push++;
    else if (m == spms_pkg::MODE_POP) n_pop++;
    else n_top++;
    if (got.status == spms_pkg::STAT_FULL && s != SEL_NONE) n_full++;
    if (got.status == spms_pkg::STAT_EMPTY && s != SEL_NONE) n_empty++;
  endtask

  // sender stops until every owed answer is back
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (resp_q.size() != 0);
  endtask

  // mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int unsigned pick_gap(bit busy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (busy || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [DATA_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: ready toggles in runs. Long ready-high stretches give
  // stall-free windows; low runs are mostly short with a few long ones.
  // ---------------------------------------------------------------------------
  int unsigned rdy_hold;

  always @(posedge clk_i) begin : rsp_ready_gen
    int unsigned r;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rdy_hold     <= 0;
    end else if (rdy_hold != 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        rsp_if.ready <= 1'b1;
        rdy_hold     <= $urandom_range(100, 300);
      end else if (r < 50) begin
        rsp_if.ready <= 1'b1;
        rdy_hold     <= $urandom_range(1, 20);
      end else if (r < 85) begin
        rsp_if.ready <= 1'b0;
        rdy_hold     <= $urandom_range(1, 3);
      end else if (r < 96) begin
        rsp_if.ready <= 1'b0;
        rdy_hold     <= $urandom_range(4, 12);
      end else begin
        rsp_if.ready <= 1'b0;
        rdy_hold     <= $urandom_range(20, 60);
      end
    end
  end

  // compare every response transaction against the oldest owed answer
  always @(posedge clk_i) begin : rsp_check
    stack_resp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (resp_q.size() == 0) begin
        flag_error($sformatf("response with none owed: status %0d data %h",
                             rsp_if.status, rsp_if.data_out));
      end else begin
        want = resp_q.pop_front();
        if (rsp_if.status !== want.status)
          flag_error($sformatf("status: expected %0d, got %0d",
                               want.status, rsp_if.status));
        if (rsp_if.data_out !== want.value)
          flag_error($sformatf("data_out: expected %h, got %h",
                               want.value, rsp_if.data_out));
      end
    end
  end

  // hard stop: far beyond a worst-case run (full scans, long stalls, clearing)
  initial begin
    #50_000_000;
    $display("timeout, %0d answers still owed", resp_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    stack_resp_t none;
    int unsigned sent, seg_len, push_pct, k, r;
    bit          busy;
    logic [MODE_W-1:0] m;
    logic [SEL_W-1:0]  s;

    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.mode      = spms_pkg::MODE_PUSH;
    req_if.stack_sel = '0;
    req_if.data_in   = '0;
    err_cnt          = 0;
    {n_push, n_pop, n_top, n_ignored, n_full, n_empty} = '0;
    none             = '0;
    for (int i = 0; i < SLOTS; i++) pool_used[i] = 1'b0;
    for (int i = 0; i < STACKS; i++) top_ptr[i] = 9'(SLOTS);
    free_hint = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows; ready stays low through the clearing pass, issue waits
    foreach (DIRECTED_OPS[i])
      issue(DIRECTED_OPS[i].mode, DIRECTED_OPS[i].sel, DIRECTED_OPS[i].data,
            pick_gap(1'b0), DIRECTED_OPS[i].known,
            '{status: DIRECTED_OPS[i].status, value: DIRECTED_OPS[i].value});
    hold_until_drained();

    // Random part in segments. The first fills the pool past full, the
    // second drains it; after that the push share is random. Pool full,
    // long scans and scan restarts after pops all come from the fills.
    sent = 0;
    k    = 0;
    while (sent < RANDOM_OPS) begin
      case (k)
        0: begin push_pct = 90; seg_len = 400; end
        1: begin push_pct = 10; seg_len = 350; end
        default: begin
          r = $urandom_range(0, 2);
          push_pct = (r == 0) ? 85 : (r == 1) ? 20 : 50;
          seg_len  = $urandom_range(40, 250);
        end
      endcase
      busy = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < int'(seg_len) && sent < RANDOM_OPS; j++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          // noise: ignored mode or the missing stack
          if (r < 2) begin
            m = MODE_NOP;
            s = SEL_W'($urandom_range(0, 3));
          end else begin
            m = MODE_W'($urandom_range(0, 3));
            s = SEL_NONE;
          end
        end else begin
          s = SEL_W'($urandom_range(0, STACKS - 1));
          if ($urandom_range(0, 99) < push_pct) m = spms_pkg::MODE_PUSH;
          else m = ($urandom_range(0, 99) < 65) ? spms_pkg::MODE_POP : spms_pkg::MODE_TOP;
        end
        issue(m, s, pick_data(), pick_gap(busy), 1'b0, none);
        sent++;
      end
      k++;
      if ($urandom_range(0, 2) == 0) hold_until_drained();
    end

    req_if.valid <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (resp_q.size() != 0)
      flag_error($sformatf("%0d answers never arrived", resp_q.size()));

    $display("Ran %0d pushes, %0d pops, %0d top reads, %0d ignored requests,",
             n_push, n_pop, n_top, n_ignored);
    $display("with %0d pool-full and %0d empty-stack answers; %0d errors.",
             n_full, n_empty, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
